FILE: src/apu_pkg.sv
// Shared types and constants for the Adam parameter update pipeline.
// Used by apu_div_pipe and adam_parameter_update_core; depends on nothing.
package apu_pkg;

  localparam int unsigned CfgDataW = 25;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEARNING_RATE    = 3'd0,
    CFG_DECAY_FIRST      = 3'd1,
    CFG_DECAY_SECOND     = 3'd2,
    CFG_EPSILON_FLOOR    = 3'd3,
    CFG_BIAS_CORR_FIRST  = 3'd4,
    CFG_BIAS_CORR_SECOND = 3'd5
  } cfg_reg_e;

  localparam logic [23:0] LR_RESET  = 24'd16777;
  localparam logic [23:0] B1_RESET  = 24'd15099494;
  localparam logic [23:0] B2_RESET  = 24'd16760439;
  localparam logic [23:0] EPS_RESET = 24'd1;
  localparam logic [24:0] C1_RESET  = 25'd1677722;
  localparam logic [24:0] C2_RESET  = 25'd16777;

  localparam logic [24:0] ONE_Q24  = 25'h100_0000;
  localparam logic [23:0] HALF_Q24 = 24'h80_0000;

  // Long-division bits resolved per pipeline stage.
  localparam int DIV_STEPS_DEFAULT = 4;
  // Square root: 40 result bits, ROOT_ROUNDS rounds per stage.
  localparam int ROOT_BITS   = 40;
  localparam int ROOT_ROUNDS = 4;

  // Per-element values that ride along with the long operations.
  typedef struct packed {
    logic        neg;
    logic [31:0] mn;
    logic [30:0] vn;
    logic [31:0] w;
  } item_t;

  localparam int ItemW = $bits(item_t);

endpackage

FILE: src/adam_parameter_update_core.sv
// Adam update: one element per cycle through the moment stages, the three division pipelines
// (K = DIV_STEPS_PER_STAGE quotient bits per stage), the ten-stage square root pipeline,
// the denominator register and the output register. Throughput is one transaction per cycle; the
// whole pipeline holds while the output register is full and stalled.
// Reset clears all valid bits and loads the register defaults.
// Depends on apu_pkg and apu_div_pipe.
module adam_parameter_update_core #(
  parameter int DIV_STEPS_PER_STAGE = apu_pkg::DIV_STEPS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [apu_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [apu_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            grad_in_i,
  input  logic signed [31:0]            first_moment_in_i,
  input  logic [30:0]                   second_moment_in_i,
  input  logic signed [31:0]            weight_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            first_moment_out_o,
  output logic [30:0]                   second_moment_out_o,
  output logic signed [31:0]            weight_out_o
);

  localparam int RootStages = apu_pkg::ROOT_BITS / apu_pkg::ROOT_ROUNDS;
  localparam int XW         = 2 * apu_pkg::ROOT_BITS;
  localparam int RootW      = apu_pkg::ROOT_BITS;
  localparam int RemW       = apu_pkg::ROOT_BITS + 2;

  // ---------------- configuration ----------------
  logic [23:0] lr_q, b1_q, b2_q, eps_q;
  logic [24:0] c1_q, c2_q;
  logic [24:0] c1_eff, c2_eff;
  logic [23:0] eps_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= apu_pkg::LR_RESET;
      b1_q  <= apu_pkg::B1_RESET;
      b2_q  <= apu_pkg::B2_RESET;
      eps_q <= apu_pkg::EPS_RESET;
      c1_q  <= apu_pkg::C1_RESET;
      c2_q  <= apu_pkg::C2_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        apu_pkg::CFG_LEARNING_RATE:    lr_q  <= cfg_data_i[23:0];
        apu_pkg::CFG_DECAY_FIRST:      b1_q  <= cfg_data_i[23:0];
        apu_pkg::CFG_DECAY_SECOND:     b2_q  <= cfg_data_i[23:0];
        apu_pkg::CFG_EPSILON_FLOOR:    eps_q <= cfg_data_i[23:0];
        apu_pkg::CFG_BIAS_CORR_FIRST:  c1_q  <= cfg_data_i;
        apu_pkg::CFG_BIAS_CORR_SECOND: c2_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a zero divisor or epsilon counts as one LSB
  assign c1_eff  = (c1_q == '0) ? 25'd1 : c1_q;
  assign c2_eff  = (c2_q == '0) ? 25'd1 : c2_q;
  assign eps_eff = (eps_q == '0) ? 24'd1 : eps_q;

  // ---------------- flow control ----------------
  logic advance;
  logic out_valid_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  // ---------------- stage 1: moment products ----------------
  logic               v1_q;
  logic signed [56:0] pm1_q, pm1_d;
  logic signed [57:0] pm2_q, pm2_d;
  logic [63:0]        gsq_q, gsq_d;
  logic [30:0]        vin1_q;
  logic [31:0]        w1_q;
  logic [24:0]        k1, k2;
  logic [31:0]        gmag;

  assign k1   = apu_pkg::ONE_Q24 - {1'b0, b1_q};
  assign k2   = apu_pkg::ONE_Q24 - {1'b0, b2_q};
  assign gmag = grad_in_i[31] ? 32'(-grad_in_i) : 32'(grad_in_i);

  always_comb begin
    pm1_d = $signed({1'b0, b1_q}) * first_moment_in_i;
    pm2_d = $signed({1'b0, k1}) * grad_in_i;
    gsq_d = 64'(gmag) * 64'(gmag);
  end

  // ---------------- stage 2: first moment, squared gradient ----------------
  logic               v2_q;
  logic [31:0]        mn2_q, mn2_d;
  logic [38:0]        g2_q, g2_d;
  logic [30:0]        vin2_q;
  logic [31:0]        w2_q;

  always_comb begin
    logic signed [58:0] msum;
    logic [34:0]        msh;
    logic [63:0]        gr;
    msum = {{2{pm1_q[56]}}, pm1_q} + {pm2_q[57], pm2_q} + 59'(apu_pkg::HALF_Q24);
    msh  = msum[58:24];
    if (msh[34:31] == 4'b0000 || msh[34:31] == 4'b1111) begin
      mn2_d = msh[31:0];
    end else begin
      mn2_d = msh[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    gr   = gsq_q + 64'(apu_pkg::HALF_Q24);
    g2_d = gr[62:24];
  end

  // ---------------- stage 3: step numerator, second moment products ----------------
  logic        v3_q;
  logic [55:0] a3_q, a3_d;
  logic [31:0] mn3_q;
  logic [54:0] pv3_q, pv3_d;
  logic [56:0] plo3_q, plo3_d;
  logic [31:0] phi3_q, phi3_d;
  logic [31:0] w3_q;

  always_comb begin
    logic [31:0] mmag;
    mmag   = mn2_q[31] ? 32'(-mn2_q) : mn2_q;
    a3_d   = 56'(mmag) * 56'(lr_q);
    pv3_d  = 55'(vin2_q) * 55'(b2_q);
    plo3_d = 57'(k2) * 57'(g2_q[31:0]);
    phi3_d = 32'(k2) * 32'(g2_q[38:32]);
  end

  // ---------------- stage 4: second moment ----------------
  logic           v4_q;
  logic [55:0]    a4_q;
  apu_pkg::item_t item4_q, item4_d;

  always_comb begin
    logic [63:0] vs;
    logic [39:0] vf;
    vs = 64'(pv3_q) + 64'(plo3_q) + {phi3_q, 32'b0} + 64'(apu_pkg::HALF_Q24);
    vf = vs[63:24];
    item4_d.neg = mn3_q[31];
    item4_d.mn  = mn3_q;
    item4_d.vn  = (vf[39:31] != '0) ? 31'h7FFF_FFFF : vf[30:0];
    item4_d.w   = w3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (advance) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pm1_q   <= pm1_d;
      pm2_q   <= pm2_d;
      gsq_q   <= gsq_d;
      vin1_q  <= second_moment_in_i;
      w1_q    <= weight_in_i;
      mn2_q   <= mn2_d;
      g2_q    <= g2_d;
      vin2_q  <= vin1_q;
      w2_q    <= w1_q;
      a3_q    <= a3_d;
      mn3_q   <= mn2_q;
      pv3_q   <= pv3_d;
      plo3_q  <= plo3_d;
      phi3_q  <= phi3_d;
      w3_q    <= w2_q;
      a4_q    <= a3_q;
      item4_q <= item4_d;
    end
  end

  // ---------------- X = v' * 2^48 / c2 ----------------
  logic           d1_valid;
  logic [78:0]    d1_x;
  logic [55:0]    d1_a;
  apu_pkg::item_t d1_item;
  logic [56+apu_pkg::ItemW-1:0] d1_side;

  apu_div_pipe #(
    .NumW(79), .DenW(25), .SideW(56 + apu_pkg::ItemW), .StepsPerStage(DIV_STEPS_PER_STAGE)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (v4_q),
    .rem_i   (25'd0),
    .num_i   ({item4_q.vn, 48'b0}),
    .den_i   (c2_eff),
    .side_i  ({a4_q, item4_q}),
    .valid_o (d1_valid),
    .quo_o   (d1_x),
    .side_o  (d1_side)
  );

  assign {d1_a, d1_item} = d1_side;

  // ---------------- r1 = |m'| * alpha / c1 ----------------
  logic           d2_valid;
  logic [55:0]    d2_r1;
  logic [78:0]    d2_x;
  apu_pkg::item_t d2_item;
  logic [79+apu_pkg::ItemW-1:0] d2_side;

  apu_div_pipe #(
    .NumW(56), .DenW(25), .SideW(79 + apu_pkg::ItemW), .StepsPerStage(DIV_STEPS_PER_STAGE)
  ) u_div_r1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (d1_valid),
    .rem_i   (25'd0),
    .num_i   (d1_a),
    .den_i   (c1_eff),
    .side_i  ({d1_x, d1_item}),
    .valid_o (d2_valid),
    .quo_o   (d2_r1),
    .side_o  (d2_side)
  );

  assign {d2_x, d2_item} = d2_side;

  // ---------------- S = floor(sqrt(X)), two bits per round ----------------
  logic           sq_valid_q [RootStages];
  logic [XW-1:0]  sq_x_q     [RootStages];
  logic [RootW-1:0] sq_root_q [RootStages];
  logic [RemW-1:0]  sq_rem_q  [RootStages];
  logic [55:0]    sq_r1_q    [RootStages];
  apu_pkg::item_t sq_item_q  [RootStages];

  for (genvar s = 0; s < RootStages; s++) begin : g_root
    logic             valid_in;
    logic [XW-1:0]    x_in;
    logic [RootW-1:0] root_in;
    logic [RemW-1:0]  rem_in;
    logic [55:0]      r1_in;
    apu_pkg::item_t   item_in;
    logic [RootW-1:0] root_d;
    logic [RemW-1:0]  rem_d;

    if (s == 0) begin : g_first
      assign valid_in = d2_valid;
      assign x_in     = {1'b0, d2_x};
      assign root_in  = '0;
      assign rem_in   = '0;
      assign r1_in    = d2_r1;
      assign item_in  = d2_item;
    end else begin : g_next
      assign valid_in = sq_valid_q[s-1];
      assign x_in     = sq_x_q[s-1];
      assign root_in  = sq_root_q[s-1];
      assign rem_in   = sq_rem_q[s-1];
      assign r1_in    = sq_r1_q[s-1];
      assign item_in  = sq_item_q[s-1];
    end

    always_comb begin
      logic [RemW+1:0]  r;
      logic [RemW+1:0]  trial;
      logic [RootW-1:0] q;
      r = {2'b0, rem_in};
      q = root_in;
      for (int j = 0; j < apu_pkg::ROOT_ROUNDS; j++) begin
        r     = {r[RemW-1:0], x_in[2*(RootW-1-s*apu_pkg::ROOT_ROUNDS-j) +: 2]};
        trial = {2'b0, q, 2'b01};
        q     = {q[RootW-2:0], 1'b0};
        if (r >= trial) begin
          r    = r - trial;
          q[0] = 1'b1;
        end
      end
      root_d = q;
      rem_d  = r[RemW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_valid_q[s] <= 1'b0;
      end else if (advance) begin
        sq_valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        sq_x_q[s]    <= x_in;
        sq_root_q[s] <= root_d;
        sq_rem_q[s]  <= rem_d;
        sq_r1_q[s]   <= r1_in;
        sq_item_q[s] <= item_in;
      end
    end
  end

  // ---------------- denominator and step cap ----------------
  logic           dn_valid_q;
  logic [40:0]    dn_den_q, dn_den_d;
  logic           dn_cap_q, dn_cap_d;
  logic [55:0]    dn_r1_q;
  apu_pkg::item_t dn_item_q;

  always_comb begin
    dn_den_d = 41'(eps_eff) + 41'(sq_root_q[RootStages-1]);
    // step would reach 256.0 or more: it saturates any weight
    dn_cap_d = sq_r1_q[RootStages-1] >= {7'b0, dn_den_d, 8'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dn_valid_q <= 1'b0;
    end else if (advance) begin
      dn_valid_q <= sq_valid_q[RootStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dn_den_q  <= dn_den_d;
      dn_cap_q  <= dn_cap_d;
      dn_r1_q   <= sq_r1_q[RootStages-1];
      dn_item_q <= sq_item_q[RootStages-1];
    end
  end

  // ---------------- step = r1 * 2^24 / D ----------------
  logic           d3_valid;
  logic [31:0]    d3_q;
  logic           d3_cap;
  apu_pkg::item_t d3_item;
  logic [apu_pkg::ItemW:0] d3_side;

  apu_div_pipe #(
    .NumW(32), .DenW(41), .SideW(1 + apu_pkg::ItemW), .StepsPerStage(DIV_STEPS_PER_STAGE)
  ) u_div_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (dn_valid_q),
    .rem_i   (dn_cap_q ? 41'd0 : dn_r1_q[48:8]),
    .num_i   ({dn_r1_q[7:0], 24'b0}),
    .den_i   (dn_den_q),
    .side_i  ({dn_cap_q, dn_item_q}),
    .valid_o (d3_valid),
    .quo_o   (d3_q),
    .side_o  (d3_side)
  );

  assign {d3_cap, d3_item} = d3_side;

  // ---------------- weight update and output register ----------------
  logic [31:0] wn_d;

  always_comb begin
    logic [32:0] step;
    logic [33:0] ws;
    logic [33:0] wsum;
    step = d3_cap ? 33'h1_0000_0000 : {1'b0, d3_q};
    ws   = {{2{d3_item.w[31]}}, d3_item.w};
    wsum = d3_item.neg ? ws + {1'b0, step} : ws - {1'b0, step};
    if (wsum[33:31] == 3'b000 || wsum[33:31] == 3'b111) begin
      wn_d = wsum[31:0];
    end else begin
      wn_d = wsum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= d3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      first_moment_out_o  <= d3_item.mn;
      second_moment_out_o <= d3_item.vn;
      weight_out_o        <= wn_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // back-pressure only ever comes from a full, stalled output register
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // integer square root leaves a remainder of at most twice the root
  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid_q[RootStages-1] |->
      sq_rem_q[RootStages-1] <= {1'b0, sq_root_q[RootStages-1], 1'b0})
    else $error("square root remainder out of bound");

  // an uncapped step keeps the upper dividend bits below the denominator
  a_step_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dn_valid_q && !dn_cap_q |-> dn_r1_q[55:8] < {7'b0, dn_den_q})
    else $error("uncapped step numerator does not fit the divider");

endmodule

FILE: src/apu_div_pipe.sv
// Pipelined restoring long division, StepsPerStage quotient bits per stage.
// Depends on apu_pkg for the default step count.
module apu_div_pipe #(
  parameter int NumW          = 32,
  parameter int DenW          = 25,
  parameter int SideW         = 8,
  parameter int StepsPerStage = apu_pkg::DIV_STEPS_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DenW-1:0]  rem_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  localparam int Stages = (NumW + StepsPerStage - 1) / StepsPerStage;

  logic             valid_q [Stages];
  logic [DenW-1:0]  rem_q   [Stages];
  logic [NumW-1:0]  num_q   [Stages];
  logic [NumW-1:0]  quo_q   [Stages];
  logic [DenW-1:0]  den_q   [Stages];
  logic [SideW-1:0] side_q  [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic             valid_in;
    logic [DenW-1:0]  rem_in;
    logic [NumW-1:0]  num_in;
    logic [NumW-1:0]  quo_in;
    logic [DenW-1:0]  den_in;
    logic [SideW-1:0] side_in;
    logic [DenW-1:0]  rem_d;
    logic [NumW-1:0]  quo_d;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = rem_i;
      assign num_in   = num_i;
      assign quo_in   = '0;
      assign den_in   = den_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign num_in   = num_q[s-1];
      assign quo_in   = quo_q[s-1];
      assign den_in   = den_q[s-1];
      assign side_in  = side_q[s-1];
    end

    always_comb begin
      logic [DenW:0]   r;
      logic [NumW-1:0] q;
      r = {1'b0, rem_in};
      q = quo_in;
      for (int j = 0; j < StepsPerStage; j++) begin
        if (s * StepsPerStage + j < NumW) begin
          r = {r[DenW-1:0], num_in[NumW-1-s*StepsPerStage-j]};
          if (r >= {1'b0, den_in}) begin
            r = r - {1'b0, den_in};
            q[NumW-1-s*StepsPerStage-j] = 1'b1;
          end
        end
      end
      rem_d = r[DenW-1:0];
      quo_d = q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        num_q[s]  <= num_in;
        quo_q[s]  <= quo_d;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign quo_o   = quo_q[Stages-1];
  assign side_o  = side_q[Stages-1];

  // the partial remainder must start below a nonzero divisor
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && en_i |-> (den_i != '0) && (rem_i < den_i))
    else $error("divider entered with remainder not below divisor");

  a_rem_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[Stages-1] |-> rem_q[Stages-1] < den_q[Stages-1])
    else $error("divider remainder left at or above divisor");

endmodule
